>>> hw/rtl/occ_pkg.sv
`default_nettype none

package occ_pkg;

  // table sizes and field widths
  localparam int unsigned MAX_CORES = 8;
  localparam int unsigned MAX_TASKS = 64;
  localparam int unsigned CORE_W    = 3;  // index of a core inside the table
  localparam int unsigned CIDX_W    = 4;  // core index as requested
  localparam int unsigned TASK_W    = 6;
  localparam int unsigned CNT_W     = 4;  // holds 0..MAX_CORES

  // request opcodes
  localparam logic OP_TAKE    = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // classified command kinds
  typedef enum logic [1:0] {
    CMD_TAKE,
    CMD_RELEASE,
    CMD_BAD
  } cmd_kind_e;

  // command word from the front end to the back end
  typedef struct packed {
    cmd_kind_e           kind;
    logic [CORE_W-1:0]   core;
    logic [TASK_W-1:0]   task_id;
  } cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/occ_if.sv
`default_nettype none

// request channel
interface occ_req_if;
  import occ_pkg::*;

  logic                valid;
  logic                ready;
  logic                opcode;
  logic [CIDX_W-1:0]   core_sel;
  logic [TASK_W-1:0]   task_sel;

  modport source (output valid, opcode, core_sel, task_sel, input ready);
  modport sink   (input valid, opcode, core_sel, task_sel, output ready);
endinterface

// result channel
interface occ_rsp_if;
  import occ_pkg::*;

  logic                valid;
  logic                ready;
  logic                status;
  logic                preempted_valid;
  logic [TASK_W-1:0]   preempted_task;
  logic [CORE_W-1:0]   affected_core;
  logic [MAX_CORES-1:0] busy_mask;
  logic [CNT_W-1:0]    busy_count;
  logic [CNT_W-1:0]    free_count;

  modport source (output valid, status, preempted_valid, preempted_task, affected_core,
                  busy_mask, busy_count, free_count, input ready);
  modport sink   (input valid, status, preempted_valid, preempted_task, affected_core,
                  busy_mask, busy_count, free_count, output ready);
endinterface

// configuration write channel
interface occ_cfg_if;
  import occ_pkg::*;

  logic                valid;
  logic                ready;
  logic [CNT_W-1:0]    data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/occ_front.sv
`default_nettype none

module occ_front (
  occ_req_if.sink                   req_i,
  input  wire logic [occ_pkg::CNT_W-1:0] active_cores_i,
  output logic                      push_valid_o,
  output occ_pkg::cmd_t             push_cmd_o,
  input  wire logic                 push_ready_i
);
  import occ_pkg::*;

  logic core_ok;

  // a take must name a core below the active count
  assign core_ok = (CNT_W'(req_i.core_sel) < active_cores_i) &&
                   (req_i.core_sel < CIDX_W'(MAX_CORES));

  // classify the request word
  always_comb begin
    push_cmd_o.core    = req_i.core_sel[CORE_W-1:0];
    push_cmd_o.task_id = req_i.task_sel;
    if (req_i.opcode == OP_RELEASE) begin
      push_cmd_o.kind = CMD_RELEASE;
    end else if (core_ok) begin
      push_cmd_o.kind = CMD_TAKE;
    end else begin
      push_cmd_o.kind = CMD_BAD;
    end
  end

  // handshake straight into the queue
  assign push_valid_o = req_i.valid;
  assign req_i.ready  = push_ready_i;

endmodule

`default_nettype wire

>>> hw/rtl/occ_queue.sv
`default_nettype none

module occ_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  wire occ_pkg::cmd_t push_cmd_i,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i,
  output occ_pkg::cmd_t      pop_cmd_o
);
  import occ_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_QW = $clog2(DEPTH + 1);

  cmd_t               mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_QW-1:0]  count_q, count_d;
  logic               push, pop;

  assign push_ready_o = (count_q != CNT_QW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer wrap and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/occ_back.sv
`default_nettype none

module occ_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  occ_cfg_if.sink                   cfg_i,
  occ_rsp_if.source                 rsp_o,
  input  wire logic                 pop_valid_i,
  input  wire occ_pkg::cmd_t        pop_cmd_i,
  output logic                      pop_ready_o,
  output logic [occ_pkg::CNT_W-1:0] active_cores_o
);
  import occ_pkg::*;

  localparam logic ST_EXEC   = 1'b0;
  localparam logic ST_LOOKUP = 1'b1;

  logic                 state_q;
  logic                 rsp_valid_q;
  logic [MAX_CORES-1:0] busy_q, busy_d;
  logic [CNT_W-1:0]     busy_total_q, busy_total_d;
  logic [CNT_W-1:0]     active_q;
  logic [MAX_TASKS-1:0] link_vld_q, link_vld_d;
  logic [TASK_W-1:0]    owner_q [MAX_CORES];
  logic [CORE_W-1:0]    link_mem [MAX_TASKS];
  logic [CORE_W-1:0]    link_rd_q;
  logic [TASK_W-1:0]    rel_task_q;

  logic                 slot_free, pop, cfg_wr;
  logic                 exec_take, exec_bad, start_rel, exec_rel, rel_ok;
  logic                 load;
  logic                 status_d, pre_valid_d;
  logic [TASK_W-1:0]    pre_task_d;
  logic [CORE_W-1:0]    affected_d;
  logic [CNT_W-1:0]     free_d;

  // result register slot and queue pop
  assign slot_free   = !rsp_valid_q || rsp_o.ready;
  assign pop_ready_o = (state_q == ST_EXEC) && slot_free;
  assign pop         = pop_valid_i && pop_ready_o;
  assign exec_take   = pop && (pop_cmd_i.kind == CMD_TAKE);
  assign exec_bad    = pop && (pop_cmd_i.kind == CMD_BAD);
  assign start_rel   = pop && (pop_cmd_i.kind == CMD_RELEASE);
  assign exec_rel    = (state_q == ST_LOOKUP) && slot_free;
  assign rel_ok      = link_vld_q[rel_task_q] && busy_q[link_rd_q];

  assign cfg_i.ready    = 1'b1;
  assign cfg_wr         = cfg_i.valid && cfg_i.ready;
  assign active_cores_o = active_q;

  // carry out the command at the head
  always_comb begin
    busy_d       = busy_q;
    busy_total_d = busy_total_q;
    load         = 1'b0;
    status_d     = STATUS_ERR;
    pre_valid_d  = 1'b0;
    pre_task_d   = '0;
    affected_d   = '0;
    if (exec_take) begin
      load       = 1'b1;
      status_d   = STATUS_OK;
      affected_d = pop_cmd_i.core;
      if (busy_q[pop_cmd_i.core]) begin
        pre_valid_d = 1'b1;
        pre_task_d  = owner_q[pop_cmd_i.core];
      end else begin
        busy_d[pop_cmd_i.core] = 1'b1;
        busy_total_d           = busy_total_q + 1'b1;
      end
    end else if (exec_bad) begin
      load = 1'b1;
    end else if (exec_rel) begin
      load = 1'b1;
      if (rel_ok) begin
        busy_d[link_rd_q] = 1'b0;
        busy_total_d      = busy_total_q - 1'b1;
        affected_d        = link_rd_q;
        status_d          = STATUS_OK;
      end
    end
    free_d = (active_q >= busy_total_d) ? active_q - busy_total_d : '0;
  end

  // preempted task loses its link, the taker gains one
  always_comb begin
    link_vld_d = link_vld_q;
    if (exec_take) begin
      if (busy_q[pop_cmd_i.core]) begin
        link_vld_d[owner_q[pop_cmd_i.core]] = 1'b0;
      end
      link_vld_d[pop_cmd_i.task_id] = 1'b1;
    end
  end

  // control state and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_EXEC;
      rsp_valid_q  <= 1'b0;
      busy_q       <= '0;
      busy_total_q <= '0;
      active_q     <= CNT_W'(MAX_CORES);
      link_vld_q   <= '0;
    end else begin
      if (cfg_wr) begin
        if (cfg_i.data inside {[1:MAX_CORES]}) begin
          active_q     <= cfg_i.data;
          busy_q       <= '0;
          busy_total_q <= '0;
        end
      end else begin
        busy_q       <= busy_d;
        busy_total_q <= busy_total_d;
      end
      if (start_rel) begin
        state_q <= ST_LOOKUP;
      end else if (exec_rel) begin
        state_q <= ST_EXEC;
      end
      if (load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      link_vld_q <= link_vld_d;
    end
  end

  // owner table, link memory and result payload
  always_ff @(posedge clk_i) begin
    if (exec_take) begin
      owner_q[pop_cmd_i.core]    <= pop_cmd_i.task_id;
      link_mem[pop_cmd_i.task_id] <= pop_cmd_i.core;
    end
    if (start_rel) begin
      link_rd_q  <= link_mem[pop_cmd_i.task_id];
      rel_task_q <= pop_cmd_i.task_id;
    end
    if (load) begin
      rsp_o.status          <= status_d;
      rsp_o.preempted_valid <= pre_valid_d;
      rsp_o.preempted_task  <= pre_task_d;
      rsp_o.affected_core   <= affected_d;
      rsp_o.busy_mask       <= busy_d;
      rsp_o.busy_count      <= busy_total_d;
      rsp_o.free_count      <= free_d;
    end
  end

  assign rsp_o.valid = rsp_valid_q;

  // busy count tracks the busy bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_total_q == CNT_W'($countones(busy_q)))
    else $error("busy count out of step with busy bits");

  // no core at or beyond the active count is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q >> active_q) == '0)
    else $error("inactive core marked busy");

  // link lookup only follows a release pop, and may wait for the result slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) |-> ($past(start_rel) || $past(state_q == ST_LOOKUP)))
    else $error("lookup state entered without a release");

endmodule

`default_nettype wire

>>> hw/rtl/core_occupancy_table_unit.sv
// channel  | dir | payload                                              | fires on
// req_i    | in  | opcode, core_sel, task_sel                          | valid & ready
// rsp_o    | out | status, preempted_valid/task, affected_core, counts  | valid & ready
// cfg_i    | in  | data = active_cores                                  | valid & ready
//
// a take completes as it is popped, a release passes through a lookup state: the
// task link table has one registered read port, looked up before the release completes
// path: queue entry, lookup state (release only), result register
// reset: all cores free, all task links cleared, active_cores = 8
// a configuration write of 1..MAX_CORES clears occupancy; owners and task links are kept
// a queue of QUEUE_DEPTH words decouples intake from the back end; the back end
// holds while the result register is full and not taken
`default_nettype none

module core_occupancy_table_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  occ_req_if.sink   req_i,
  occ_rsp_if.source rsp_o,
  occ_cfg_if.sink   cfg_i
);
  import occ_pkg::*;

  logic             push_valid, push_ready;
  logic             pop_valid, pop_ready;
  cmd_t             push_cmd, pop_cmd;
  logic [CNT_W-1:0] active_cores;

  // intake and classification
  occ_front u_front (
    .req_i          (req_i),
    .active_cores_i (active_cores),
    .push_valid_o   (push_valid),
    .push_cmd_o     (push_cmd),
    .push_ready_i   (push_ready)
  );

  // command queue
  occ_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // table update and result
  occ_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_i),
    .rsp_o          (rsp_o),
    .pop_valid_i    (pop_valid),
    .pop_cmd_i      (pop_cmd),
    .pop_ready_o    (pop_ready),
    .active_cores_o (active_cores)
  );

endmodule

`default_nettype wire

>>> tb/tb_core_occupancy_table_unit.sv
`default_nettype none

module tb_core_occupancy_table_unit;
  import occ_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_PER_PHASE = 225;
  localparam int unsigned TASK_POOL = 12;

  // one result word as the block returns it
  typedef struct packed {
    logic                 status;
    logic                 preempted_valid;
    logic [TASK_W-1:0]    preempted_task;
    logic [CORE_W-1:0]    affected_core;
    logic [MAX_CORES-1:0] busy_mask;
    logic [CNT_W-1:0]     busy_count;
    logic [CNT_W-1:0]     free_count;
  } table_result_t;

  // mirror of the occupancy table plus the results still owed
  class occupancy_tracker;
    logic [CNT_W-1:0]     active_cores;
    logic [MAX_CORES-1:0] busy_bits;
    logic [TASK_W-1:0]    core_owner [MAX_CORES];
    logic [CORE_W-1:0]    task_core [MAX_TASKS];
    bit                   task_linked [MAX_TASKS];
    logic [CNT_W-1:0]     busy_total;
    table_result_t        expected_results [$];
    int unsigned          mismatches;

    function new();
      active_cores = CNT_W'(MAX_CORES);
      clear_cores();
      foreach (task_core[i]) begin
        task_core[i] = '0;
        task_linked[i] = 1'b0;
      end
      mismatches = 0;
    endfunction

    function void clear_cores();
      busy_bits = '0;
      busy_total = '0;
      foreach (core_owner[i]) core_owner[i] = '0;
    endfunction

    // out-of-range counts are dropped, task links survive a write
    function void write_active(logic [CNT_W-1:0] value);
      if (value >= 1 && value <= MAX_CORES) begin
        active_cores = value;
        clear_cores();
      end
    endfunction

    // apply one accepted request and queue the word it must produce
    function void note_request(logic opcode, logic [CIDX_W-1:0] core_sel,
                               logic [TASK_W-1:0] task_id);
      table_result_t      res;
      logic [CORE_W-1:0]  slot;
      res = '0;
      res.status = STATUS_ERR;
      if (opcode == OP_TAKE) begin
        if (core_sel < active_cores) begin
          slot = core_sel[CORE_W-1:0];
          if (!busy_bits[slot]) begin
            busy_bits[slot] = 1'b1;
            busy_total = busy_total + 1'b1;
          end else begin
            // displaced owner loses its link, even when it is the same task
            res.preempted_valid = 1'b1;
            res.preempted_task = core_owner[slot];
            task_linked[core_owner[slot]] = 1'b0;
          end
          task_core[task_id] = slot;
          task_linked[task_id] = 1'b1;
          core_owner[slot] = task_id;
          res.affected_core = slot;
          res.status = STATUS_OK;
        end
      end else begin
        // release follows the link even if another task took the core since
        slot = task_core[task_id];
        if (task_linked[task_id] && busy_bits[slot]) begin
          busy_bits[slot] = 1'b0;
          if (busy_total != 0) busy_total = busy_total - 1'b1;
          res.affected_core = slot;
          res.status = STATUS_OK;
        end
      end
      res.busy_mask = busy_bits;
      res.busy_count = busy_total;
      res.free_count = active_cores - busy_total;
      expected_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
    endfunction

    // compare one returned word against the oldest one owed
    function void check_result(table_result_t got);
      table_result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none got %h", $time, got);
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", 8'(want.status), 8'(got.status));
      compare_field("preempted_valid", 8'(want.preempted_valid), 8'(got.preempted_valid));
      compare_field("preempted_task", 8'(want.preempted_task), 8'(got.preempted_task));
      compare_field("affected_core", 8'(want.affected_core), 8'(got.affected_core));
      compare_field("busy_mask", 8'(want.busy_mask), 8'(got.busy_mask));
      compare_field("busy_count", 8'(want.busy_count), 8'(got.busy_count));
      compare_field("free_count", 8'(want.free_count), 8'(got.free_count));
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  bit               steady_flow;
  int unsigned      cycle_count;
  logic [CNT_W-1:0] active_setting;
  occupancy_tracker tracker;

  occ_req_if req_if ();
  occ_rsp_if rsp_if ();
  occ_cfg_if cfg_if ();

  core_occupancy_table_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side backpressure
  always @(posedge clk_i) begin
    rsp_if.ready <= steady_flow || ($urandom_range(99) >= 10);
  end

  // watch all three channels at each edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        tracker.check_result('{rsp_if.status, rsp_if.preempted_valid, rsp_if.preempted_task,
                               rsp_if.affected_core, rsp_if.busy_mask, rsp_if.busy_count,
                               rsp_if.free_count});
      end
      if (req_if.valid && req_if.ready)
        tracker.note_request(req_if.opcode, req_if.core_sel, req_if.task_sel);
      if (cfg_if.valid && cfg_if.ready)
        tracker.write_active(cfg_if.data);
    end
  end

  // present one request word and hold it until taken
  task automatic send_request(logic opcode, logic [CIDX_W-1:0] core_sel,
                              logic [TASK_W-1:0] task_id);
    while (!steady_flow && $urandom_range(99) < 10) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.opcode <= opcode;
    req_if.core_sel <= core_sel;
    req_if.task_sel <= task_id;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // stop sending and let every owed word come back
  task automatic wait_drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.expected_results.size() != 0);
  endtask

  // register write, only with the block idle
  task automatic write_active_cores(logic [CNT_W-1:0] value);
    wait_drain();
    repeat (4) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    if (value >= 1 && value <= MAX_CORES) active_setting = value;
  endtask

  // mostly valid takes and releases over a small task pool for contention
  task automatic send_random_requests(int unsigned count, bit pause_midway);
    logic               opcode;
    logic [CIDX_W-1:0]  core_sel;
    logic [TASK_W-1:0]  task_id;
    for (int unsigned n = 0; n < count; n++) begin
      if (pause_midway && n == count / 2) wait_drain();
      opcode = ($urandom_range(99) < 55) ? OP_TAKE : OP_RELEASE;
      if (opcode == OP_TAKE && $urandom_range(99) < 85)
        core_sel = CIDX_W'($urandom_range(active_setting - 1));
      else
        core_sel = CIDX_W'($urandom_range(15));
      if ($urandom_range(99) < 85)
        task_id = TASK_W'($urandom_range(TASK_POOL - 1));
      else
        task_id = TASK_W'($urandom_range(MAX_TASKS - 1));
      send_request(opcode, core_sel, task_id);
    end
  endtask

  initial begin
    logic [CNT_W-1:0] plan [8];
    plan = '{4'd8, 4'd1, 4'd5, 4'd3, 4'd8, 4'd2, 4'd7, 4'd4};
    tracker = new();
    steady_flow = 1'b0;
    cycle_count = 0;
    active_setting = CNT_W'(MAX_CORES);
    rst_ni = 1'b0;
    req_if.valid <= 1'b0;
    req_if.opcode <= OP_TAKE;
    req_if.core_sel <= '0;
    req_if.task_sel <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: all eight cores active after reset
    send_request(OP_RELEASE, 4'd0, 6'd0);   // no link yet
    send_request(OP_TAKE, 4'd0, 6'd0);
    send_request(OP_TAKE, 4'd7, 6'd63);
    send_request(OP_TAKE, 4'd15, 6'd5);     // bad core, top index
    send_request(OP_TAKE, 4'd8, 6'd5);      // bad core, first past the end
    send_request(OP_TAKE, 4'd7, 6'd10);     // preempts task 63
    send_request(OP_TAKE, 4'd7, 6'd10);     // same task preempts itself
    send_request(OP_RELEASE, 4'd0, 6'd63);  // preempted task has no link
    send_request(OP_RELEASE, 4'd0, 6'd10);
    send_request(OP_RELEASE, 4'd0, 6'd10);  // linked core already free
    send_request(OP_TAKE, 4'd5, 6'd30);
    send_request(OP_RELEASE, 4'd15, 6'd30);
    send_request(OP_TAKE, 4'd5, 6'd31);
    send_request(OP_RELEASE, 4'd0, 6'd30);  // stale link frees task 31's core
    send_request(OP_RELEASE, 4'd0, 6'd31);
    send_request(OP_TAKE, 4'd3, 6'd42);
    write_active_cores(4'd15);              // out of range, table kept
    send_request(OP_RELEASE, 4'd0, 6'd42);
    write_active_cores(4'd0);               // out of range too
    send_request(OP_TAKE, 4'd1, 6'd21);
    write_active_cores(4'd1);               // clears cores, links stay
    send_request(OP_RELEASE, 4'd0, 6'd0);
    send_request(OP_TAKE, 4'd1, 6'd2);
    send_request(OP_TAKE, 4'd0, 6'd2);
    send_request(OP_TAKE, 4'd0, 6'd63);
    send_request(OP_RELEASE, 4'd0, 6'd63);
    write_active_cores(4'd9);

    // random phases across core counts
    foreach (plan[p]) begin
      write_active_cores(plan[p]);
      steady_flow = (p == 4);
      send_random_requests(RANDOM_PER_PHASE, p == 2);
    end
    steady_flow = 1'b0;

    wait_drain();
    repeat (10) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
